### rtl/sega_pkg.sv
// Shared types and constants for the spectral envelope gain block.
package sega_pkg;
	localparam int MaxPoints = 16;
	localparam int IdxW = 4;
	localparam int FreqW = 22;
	localparam int GainW = 16;
	localparam int AmpW = 24;
	localparam int BinW = 24;
	localparam int CfgW = 18;
	localparam int QDepth = 2;
	localparam logic [GainW-1:0] UnityGain = 16'd16384;

	localparam logic [1:0] RegPointCount = 2'd0;
	localparam logic [1:0] RegSampleRate = 2'd1;
	localparam logic [1:0] RegFftSize = 2'd2;

	localparam logic OpWrite = 1'b0;
	localparam logic OpApply = 1'b1;

	typedef struct packed {
		logic [BinW-1:0] bin;
		logic [AmpW-1:0] amp;
		logic last;
	} job_t;
endpackage

### rtl/spectral_envelope_gain_apply.sv
// Top level: config registers, front end classification, job queue, gain engine.
// Paths: bypass with fft_size 0, unity gain with no breakpoints, the gain of an end point when
// clamped to it, or a segment search followed by interpolation when between two points.
// The engine runs one apply item at a time and takes no new job until its result is out; a
// write item waits until queue and engine are empty and makes no result.
// Reset: point_count 0, sample_rate 48000, fft_size 1024; table undefined until written.
module spectral_envelope_gain_apply (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [sega_pkg::CfgW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic [3:0] point_index,
	input  logic [21:0] point_freq,
	input  logic [15:0] point_gain,
	input  logic [23:0] bin,
	input  logic signed [23:0] amp,
	input  logic last_partial,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [23:0] amp_out,
	output logic [15:0] gain_used,
	output logic saturated,
	output logic last_out
);
	logic [4:0] point_count_q;
	logic [17:0] sample_rate_q;
	logic [16:0] fft_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 5'd0;
			sample_rate_q <= 18'd48000;
			fft_size_q <= 17'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				sega_pkg::RegPointCount: point_count_q <= cfg_data[4:0];
				sega_pkg::RegSampleRate: sample_rate_q <= cfg_data;
				sega_pkg::RegFftSize: fft_size_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	logic q_full, q_empty, q_pop, push, wr_en, eng_busy;
	sega_pkg::job_t push_data, pop_data;

	// table writes wait while jobs are queued or in the engine so reads see program order
	assign in_stall = q_full || (opcode == sega_pkg::OpWrite && (!q_empty || eng_busy));
	assign push = in_valid && !in_stall && opcode == sega_pkg::OpApply;
	assign wr_en = in_valid && !in_stall && opcode == sega_pkg::OpWrite;
	assign push_data = '{bin: bin, amp: amp, last: last_partial};

	sega_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(q_full), .pop(q_pop), .empty(q_empty), .pop_data(pop_data));

	sega_engine u_engine (
		.clk(clk), .arst_n(arst_n), .job_valid(!q_empty), .job(pop_data),
		.job_pop(q_pop), .busy(eng_busy), .point_count(point_count_q),
		.sample_rate(sample_rate_q),
		.fft_size(fft_size_q), .wr_en(wr_en), .wr_idx(point_index),
		.wr_freq(point_freq), .wr_gain(point_gain), .valid(out_valid),
		.stall(out_stall), .amp_out(amp_out), .gain_used(gain_used),
		.saturated(saturated), .last_out(last_out));
endmodule

### rtl/sega_ram.sv
// Generic single-port-write, registered-read RAM.
module sega_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/sega_queue.sv
// Short job queue between the front end and the gain engine.
module sega_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sega_pkg::job_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output sega_pkg::job_t pop_data
);
	sega_pkg::job_t buf_q [sega_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### rtl/sega_engine.sv
// Back end: frequency, segment search, interpolation and amplitude scaling.
module sega_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  sega_pkg::job_t job,
	output logic job_pop,
	output logic busy,
	input  logic [4:0] point_count,
	input  logic [17:0] sample_rate,
	input  logic [16:0] fft_size,
	input  logic wr_en,
	input  logic [sega_pkg::IdxW-1:0] wr_idx,
	input  logic [sega_pkg::FreqW-1:0] wr_freq,
	input  logic [sega_pkg::GainW-1:0] wr_gain,
	output logic valid,
	input  logic stall,
	output logic signed [sega_pkg::AmpW-1:0] amp_out,
	output logic [sega_pkg::GainW-1:0] gain_used,
	output logic saturated,
	output logic last_out
);
	typedef enum logic [3:0] {
		S_IDLE, S_FDIV, S_FIRST, S_LASTRD, S_LASTCHK, S_SEARCH,
		S_PAIR, S_TDIV, S_MIX, S_MUL, S_SCALE, S_OUT
	} state_t;
	state_t state_q;

	logic [sega_pkg::IdxW-1:0] raddr;
	logic [sega_pkg::FreqW-1:0] rfreq;
	logic [sega_pkg::GainW-1:0] rgain;

	sega_ram #(.Width(sega_pkg::FreqW), .Depth(sega_pkg::MaxPoints)) u_freq (
		.clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(wr_freq),
		.raddr(raddr), .rdata(rfreq));
	sega_ram #(.Width(sega_pkg::GainW), .Depth(sega_pkg::MaxPoints)) u_gain (
		.clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(wr_gain),
		.raddr(raddr), .rdata(rgain));

	// shared restoring divider: numerator up to 42 bits, divisor up to 22
	logic [41:0] num_q;
	logic [22:0] rem_q;
	logic [21:0] den_q;
	logic [5:0] cnt_q;
	logic [23:0] rem_sh;
	logic [23:0] rem_sub;
	assign rem_sh = {rem_q, num_q[41]};
	assign rem_sub = rem_sh - {2'b0, den_q};

	logic [41:0] f_q;
	logic [41:0] bin_prod;
	logic signed [sega_pkg::AmpW-1:0] amp_q;
	logic last_q;
	logic [3:0] lastidx_q;
	logic [3:0] i_q;
	logic [sega_pkg::FreqW-1:0] f0_q;
	logic [sega_pkg::GainW-1:0] g0_q, g1_q, gain_q;
	logic signed [40:0] prod_q;
	logic bypass_q;
	logic [4:0] cnt_clip;

	assign cnt_clip = (point_count > 5'd16) ? 5'd16 : point_count;
	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign busy = (state_q != S_IDLE);
	assign bin_prod = job.bin * sample_rate;

	always_comb begin
		case (state_q)
			S_FIRST: raddr = 4'd0;
			S_LASTRD: raddr = lastidx_q;
			S_SEARCH: raddr = i_q + 4'd1;
			S_PAIR: raddr = i_q + 4'd1;
			default: raddr = i_q;
		endcase
	end

	// fraction is the divider quotient, clamped to one
	logic [16:0] t_mix;
	logic [32:0] g_mix;
	always_comb begin
		t_mix = (num_q > 42'd65536) ? 17'd65536 : num_q[16:0];
		g_mix = {1'b0, g0_q} * (17'd65536 - t_mix) + {1'b0, g1_q} * t_mix;
	end

	logic signed [40:0] q_val;
	always_comb begin
		if (prod_q >= 0) q_val = prod_q >>> 14;
		else q_val = -((-prod_q + 41'sd16383) >>> 14);
	end

	logic f_le0, f_gt_next;
	assign f_le0 = f_q <= {20'd0, rfreq};
	assign f_gt_next = {20'd0, rfreq} < f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						amp_q <= job.amp;
						last_q <= job.last;
						lastidx_q <= 4'(cnt_clip - 5'd1);
						i_q <= 4'd0;
						if (fft_size == 17'd0) begin
							bypass_q <= 1'b1;
							gain_q <= sega_pkg::UnityGain;
							state_q <= S_OUT;
						end else begin
							bypass_q <= 1'b0;
							num_q <= bin_prod;
							den_q <= {1'b0, fft_size, 4'd0};
							rem_q <= '0;
							cnt_q <= 6'd0;
							state_q <= S_FDIV;
						end
					end
				end
				S_FDIV, S_TDIV: begin
					if (rem_sub[23] == 1'b0) begin
						rem_q <= rem_sub[22:0];
						num_q <= {num_q[40:0], 1'b1};
					end else begin
						rem_q <= rem_sh[22:0];
						num_q <= {num_q[40:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd41) begin
						if (state_q == S_FDIV) begin
							state_q <= (cnt_clip == 5'd0) ? S_MUL : S_FIRST;
							gain_q <= sega_pkg::UnityGain;
						end else begin
							state_q <= S_MIX;
						end
					end
				end
				S_FIRST: begin
					f_q <= num_q;
					state_q <= S_LASTRD;
				end
				S_LASTRD: begin
					// rdata holds entry 0
					if (cnt_clip == 5'd1 || f_le0) begin
						gain_q <= rgain;
						state_q <= S_MUL;
					end else begin
						state_q <= S_LASTCHK;
					end
				end
				S_LASTCHK: begin
					if (f_q >= {20'd0, rfreq}) begin
						gain_q <= rgain;
						state_q <= S_MUL;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					// rdata holds entry i; keep it as the segment start
					f0_q <= rfreq;
					g0_q <= rgain;
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					// rdata holds entry i+1
					if (i_q < lastidx_q - 4'd1 && f_gt_next) begin
						i_q <= i_q + 4'd1;
						state_q <= S_SEARCH;
					end else begin
						g1_q <= rgain;
						rem_q <= '0;
						cnt_q <= 6'd0;
						if (rfreq > f0_q && f_q > {20'd0, f0_q}) begin
							num_q <= (f_q - {20'd0, f0_q}) << 16;
							den_q <= rfreq - f0_q;
						end else begin
							num_q <= '0;
							den_q <= 22'd1;
						end
						state_q <= S_TDIV;
					end
				end
				default: begin
					if (state_q == S_MIX) begin
						gain_q <= 16'(g_mix >> 16);
						state_q <= S_MUL;
					end else if (state_q == S_MUL) begin
						prod_q <= 41'(amp_q) * $signed({25'd0, gain_q});
						state_q <= S_SCALE;
					end else if (state_q == S_SCALE) begin
						state_q <= S_OUT;
					end else if (state_q == S_OUT) begin
						if (!valid || !stall) begin
							valid <= 1'b1;
							gain_used <= gain_q;
							last_out <= last_q;
							if (bypass_q) begin
								amp_out <= amp_q;
								saturated <= 1'b0;
							end else if (q_val > 41'sd8388607) begin
								amp_out <= 24'sh7FFFFF;
								saturated <= 1'b1;
							end else if (q_val < -41'sd8388608) begin
								amp_out <= 24'sh800000;
								saturated <= 1'b1;
							end else begin
								amp_out <= 24'(q_val);
								saturated <= 1'b0;
							end
							state_q <= S_IDLE;
						end
					end
				end
			endcase
			if (valid && !stall && !(state_q == S_OUT)) valid <= 1'b0;
		end
	end
endmodule
